>>> sv/pid_pwm_duty_controller_macros.svh
// ----------------------------------------------------------------------------
// pid pwm duty controller assertion macros
// shared assertion wrappers, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef PID_PWM_DUTY_CONTROLLER_MACROS_SVH
`define PID_PWM_DUTY_CONTROLLER_MACROS_SVH

// same-cycle implication
`define PPDC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ppdc_pkg.sv
// ----------------------------------------------------------------------------
// ppdc_pkg
// constants, register indexes and reset values of the pid pwm duty controller
// ----------------------------------------------------------------------------
package ppdc_pkg;

  // parameter defaults
  localparam int PWM_BITS_DEF  = 12;
  localparam int FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int SAMPLE_W    = 32;
  localparam int GAIN_W      = 32;
  localparam int DUTY_REG_W  = 12;
  localparam int STALL_CNT_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_SAMPLES  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_DUTY_MIN = 3'd7;

  // register reset values
  localparam logic [DUTY_REG_W-1:0]  DUTY_CEILING_RST   = 12'd4095;
  localparam logic [STALL_CNT_W-1:0] STALL_SAMPLES_RST  = 16'd100;
  localparam logic [DUTY_REG_W-1:0]  STALL_DUTY_MIN_RST = 12'd4;

  // request kind carried down the pipeline
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_NORMAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRIME  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FAULT  = 2'd2;

endpackage

>>> sv/pid_pwm_duty_controller.sv
// ----------------------------------------------------------------------------
// pid_pwm_duty_controller
// pid controller with derivative on measurement and integrator anti-windup,
// one q16.16 sensor sample in, one pwm duty count out
// ----------------------------------------------------------------------------
// pipeline: input reg, four stages, output reg
// throughput: one request per cycle while out_stall does not hold the output;
//   the integrator loop closes in one stage (integrator add and clamp), so
//   back-to-back samples never wait on it
// reset (rst, synchronous): registers go to their defaults, integrator,
//   previous sample and unchanged count clear, controller is unprimed
// ----------------------------------------------------------------------------
`include "pid_pwm_duty_controller_macros.svh"

module pid_pwm_duty_controller #(
  parameter int PWM_BITS  = ppdc_pkg::PWM_BITS_DEF,
  parameter int FRAC_BITS = ppdc_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_write,
  input  logic [ppdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppdc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ppdc_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 sample_valid,
  // duty channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [PWM_BITS-1:0]                  duty,
  output logic                                 stalled,
  output logic                                 sensor_fault
);

  // widths of the datapath
  localparam int DIFF_W  = ppdc_pkg::SAMPLE_W + 1;              // sample difference
  localparam int PROD_W  = DIFF_W + ppdc_pkg::GAIN_W + 1;       // full gain product
  localparam int MUL_W   = PROD_W - FRAC_BITS;                  // product back in q
  localparam int DELTA_W = MUL_W + 1;                           // integral minus prop
  localparam int SUM_W   = MUL_W + 2;                           // integrator sums
  localparam int INTEG_W = PWM_BITS + FRAC_BITS;                // integrator in counts
  localparam int LIM_W   = (PWM_BITS > ppdc_pkg::DUTY_REG_W) ?
                           PWM_BITS : ppdc_pkg::DUTY_REG_W;
  localparam logic [LIM_W-1:0] PWM_MAX = LIM_W'((64'd1 << PWM_BITS) - 64'd1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [ppdc_pkg::SAMPLE_W-1:0]  setpoint;
  logic [ppdc_pkg::GAIN_W-1:0]           gain_prop;
  logic [ppdc_pkg::GAIN_W-1:0]           gain_integ;
  logic [ppdc_pkg::GAIN_W-1:0]           gain_deriv;
  logic [ppdc_pkg::DUTY_REG_W-1:0]       duty_floor;
  logic [ppdc_pkg::DUTY_REG_W-1:0]       duty_ceiling;
  logic [ppdc_pkg::STALL_CNT_W-1:0]      stall_samples;
  logic [ppdc_pkg::DUTY_REG_W-1:0]       stall_duty_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= '0;
      gain_prop      <= '0;
      gain_integ     <= '0;
      gain_deriv     <= '0;
      duty_floor     <= '0;
      duty_ceiling   <= ppdc_pkg::DUTY_CEILING_RST;
      stall_samples  <= ppdc_pkg::STALL_SAMPLES_RST;
      stall_duty_min <= ppdc_pkg::STALL_DUTY_MIN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        ppdc_pkg::REG_SETPOINT: begin
          setpoint <= $signed(cfg_data[ppdc_pkg::SAMPLE_W-1:0]);
        end
        ppdc_pkg::REG_GAIN_PROP: begin
          gain_prop <= cfg_data[ppdc_pkg::GAIN_W-1:0];
        end
        ppdc_pkg::REG_GAIN_INTEG: begin
          gain_integ <= cfg_data[ppdc_pkg::GAIN_W-1:0];
        end
        ppdc_pkg::REG_GAIN_DERIV: begin
          gain_deriv <= cfg_data[ppdc_pkg::GAIN_W-1:0];
        end
        ppdc_pkg::REG_DUTY_FLOOR: begin
          duty_floor <= cfg_data[ppdc_pkg::DUTY_REG_W-1:0];
        end
        ppdc_pkg::REG_DUTY_CEILING: begin
          duty_ceiling <= cfg_data[ppdc_pkg::DUTY_REG_W-1:0];
        end
        ppdc_pkg::REG_STALL_SAMPLES: begin
          stall_samples <= cfg_data[ppdc_pkg::STALL_CNT_W-1:0];
        end
        ppdc_pkg::REG_STALL_DUTY_MIN: begin
          stall_duty_min <= cfg_data[ppdc_pkg::DUTY_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // duty limits, saturated to the pwm range, and the same limits in q format
  logic [LIM_W-1:0]          floor_ext;
  logic [LIM_W-1:0]          ceil_ext;
  logic [PWM_BITS-1:0]       lo_lim;
  logic [PWM_BITS-1:0]       hi_lim;
  logic signed [SUM_W-1:0]   lo_q;
  logic signed [SUM_W-1:0]   hi_q;

  assign floor_ext = LIM_W'(duty_floor);
  assign ceil_ext  = LIM_W'(duty_ceiling);
  assign lo_lim    = (floor_ext > PWM_MAX) ? PWM_MAX[PWM_BITS-1:0] : floor_ext[PWM_BITS-1:0];
  assign hi_lim    = (ceil_ext > PWM_MAX) ? PWM_MAX[PWM_BITS-1:0] : ceil_ext[PWM_BITS-1:0];
  assign lo_q      = $signed({{(SUM_W-INTEG_W){1'b0}}, lo_lim, {FRAC_BITS{1'b0}}});
  assign hi_q      = $signed({{(SUM_W-INTEG_W){1'b0}}, hi_lim, {FRAC_BITS{1'b0}}});

  // --------------------------------------------------------------------------
  // elastic pipeline control: a stage loads when it is empty or drains
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, out_rdy;
  logic in_acc, mv12, mv23, mv34, mv45, mv5o;

  assign out_rdy  = !out_valid || !out_stall;
  assign s5_rdy   = !s5_valid || out_rdy;
  assign s4_rdy   = !s4_valid || s5_rdy;
  assign s3_rdy   = !s3_valid || s4_rdy;
  assign s2_rdy   = !s2_valid || s3_rdy;
  assign s1_rdy   = !s1_valid || s2_rdy;
  assign in_stall = !s1_rdy;

  assign in_acc = in_valid && s1_rdy;
  assign mv12   = s1_valid && s2_rdy;
  assign mv23   = s2_valid && s3_rdy;
  assign mv34   = s3_valid && s4_rdy;
  assign mv45   = s4_valid && s5_rdy;
  assign mv5o   = s5_valid && out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid <= in_valid;
      end
      if (s2_rdy) begin
        s2_valid <= s1_valid;
      end
      if (s3_rdy) begin
        s3_valid <= s2_valid;
      end
      if (s4_rdy) begin
        s4_valid <= s3_valid;
      end
      if (s5_rdy) begin
        s5_valid <= s4_valid;
      end
      if (out_rdy) begin
        out_valid <= s5_valid;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: input register
  // --------------------------------------------------------------------------
  logic signed [ppdc_pkg::SAMPLE_W-1:0] s1_sample;
  logic                                 s1_ok;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample <= sample;
      s1_ok     <= sample_valid;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1 -> 2: classify, differences, unchanged counter, previous sample
  // --------------------------------------------------------------------------
  logic signed [ppdc_pkg::SAMPLE_W-1:0] previous_sample;
  logic                                 primed;
  logic [ppdc_pkg::STALL_CNT_W-1:0]     unchanged_count;
  logic [ppdc_pkg::STALL_CNT_W-1:0]     unchanged_count_next;
  logic [ppdc_pkg::KIND_W-1:0]          kind1;
  logic signed [DIFF_W-1:0]             diff1;
  logic signed [DIFF_W-1:0]             err1;

  always_comb begin
    if (!s1_ok) begin
      kind1 = ppdc_pkg::KIND_FAULT;
    end else if (!primed) begin
      kind1 = ppdc_pkg::KIND_PRIME;
    end else begin
      kind1 = ppdc_pkg::KIND_NORMAL;
    end
    diff1 = $signed({s1_sample[ppdc_pkg::SAMPLE_W-1], s1_sample})
          - $signed({previous_sample[ppdc_pkg::SAMPLE_W-1], previous_sample});
    err1  = $signed({setpoint[ppdc_pkg::SAMPLE_W-1], setpoint})
          - $signed({s1_sample[ppdc_pkg::SAMPLE_W-1], s1_sample});
    // saturating count of repeated samples
    if (s1_sample != previous_sample) begin
      unchanged_count_next = '0;
    end else if (unchanged_count == '1) begin
      unchanged_count_next = unchanged_count;
    end else begin
      unchanged_count_next = unchanged_count + 1'b1;
    end
  end

  // invalid samples leave all of this untouched
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      primed          <= 1'b0;
      unchanged_count <= '0;
    end else if (mv12 && s1_ok) begin
      previous_sample <= s1_sample;
      primed          <= 1'b1;
      unchanged_count <= primed ? unchanged_count_next : '0;
    end
  end

  logic [ppdc_pkg::KIND_W-1:0] s2_kind;
  logic signed [DIFF_W-1:0]    s2_diff;
  logic signed [DIFF_W-1:0]    s2_err;
  logic                        s2_over;

  always_ff @(posedge clk) begin
    if (mv12) begin
      s2_kind <= kind1;
      s2_diff <= diff1;
      s2_err  <= err1;
      s2_over <= unchanged_count_next > stall_samples;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2 -> 3: the three gain products, floored back to q format
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_integ;
  logic signed [PROD_W-1:0] prod_prop;
  logic signed [PROD_W-1:0] prod_deriv;

  assign prod_integ = s2_err  * $signed({1'b0, gain_integ});
  assign prod_prop  = s2_diff * $signed({1'b0, gain_prop});
  assign prod_deriv = s2_diff * $signed({1'b0, gain_deriv});

  logic [ppdc_pkg::KIND_W-1:0] s3_kind;
  logic                        s3_over;
  logic signed [MUL_W-1:0]     s3_mi;
  logic signed [MUL_W-1:0]     s3_mp;
  logic signed [MUL_W-1:0]     s3_md;

  // dropping the low bits of a two's complement value rounds toward minus infinity
  always_ff @(posedge clk) begin
    if (mv23) begin
      s3_kind <= s2_kind;
      s3_over <= s2_over;
      s3_mi   <= prod_integ[PROD_W-1:FRAC_BITS];
      s3_mp   <= prod_prop[PROD_W-1:FRAC_BITS];
      s3_md   <= prod_deriv[PROD_W-1:FRAC_BITS];
    end
  end

  // --------------------------------------------------------------------------
  // stage 3 -> 4: integral term minus proportional term
  // --------------------------------------------------------------------------
  logic [ppdc_pkg::KIND_W-1:0] s4_kind;
  logic                        s4_over;
  logic signed [DELTA_W-1:0]   s4_delta;
  logic signed [MUL_W-1:0]     s4_md;

  always_ff @(posedge clk) begin
    if (mv34) begin
      s4_kind  <= s3_kind;
      s4_over  <= s3_over;
      s4_delta <= $signed({s3_mi[MUL_W-1], s3_mi}) - $signed({s3_mp[MUL_W-1], s3_mp});
      s4_md    <= s3_md;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4 -> 5: integrator update with clamp (ceiling tested first)
  // --------------------------------------------------------------------------
  logic [INTEG_W-1:0]      integrator;
  logic signed [SUM_W-1:0] integ_sum;
  logic signed [SUM_W-1:0] integ_clamp;
  logic [INTEG_W-1:0]      integrator_next;

  always_comb begin
    integ_sum = $signed({{(SUM_W-INTEG_W){1'b0}}, integrator})
              + $signed({s4_delta[DELTA_W-1], s4_delta});
    if (integ_sum > hi_q) begin
      integ_clamp = hi_q;
    end else if (integ_sum < lo_q) begin
      integ_clamp = lo_q;
    end else begin
      integ_clamp = integ_sum;
    end
    integrator_next = integ_clamp[INTEG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
    end else if (mv45 && (s4_kind == ppdc_pkg::KIND_NORMAL)) begin
      integrator <= integrator_next;
    end
  end

  logic [ppdc_pkg::KIND_W-1:0] s5_kind;
  logic                        s5_over;
  logic [INTEG_W-1:0]          s5_integ;
  logic signed [MUL_W-1:0]     s5_md;

  always_ff @(posedge clk) begin
    if (mv45) begin
      s5_kind  <= s4_kind;
      s5_over  <= s4_over;
      s5_integ <= integrator_next;
      s5_md    <= s4_md;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5 -> out: derivative on measurement, clamp, stall cut-off
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] acc_clamp;
  logic [PWM_BITS-1:0]     duty_raw;
  logic                    stall_hit;

  always_comb begin
    acc = $signed({{(SUM_W-INTEG_W){1'b0}}, s5_integ})
        - $signed({{2{s5_md[MUL_W-1]}}, s5_md});
    if (acc > hi_q) begin
      acc_clamp = hi_q;
    end else if (acc < lo_q) begin
      acc_clamp = lo_q;
    end else begin
      acc_clamp = acc;
    end
    // clamped value is never negative, so dropping the fraction is the floor
    duty_raw  = acc_clamp[INTEG_W-1:FRAC_BITS];
    stall_hit = s5_over && (LIM_W'(duty_raw) > LIM_W'(stall_duty_min));
  end

  always_ff @(posedge clk) begin
    if (mv5o) begin
      case (s5_kind)
        ppdc_pkg::KIND_FAULT: begin
          // bad sensor reading: floor duty, state untouched upstream
          duty         <= lo_lim;
          stalled      <= 1'b0;
          sensor_fault <= 1'b1;
        end
        ppdc_pkg::KIND_PRIME: begin
          // first good sample only primes the difference path
          duty         <= '0;
          stalled      <= 1'b0;
          sensor_fault <= 1'b0;
        end
        ppdc_pkg::KIND_NORMAL: begin
          duty         <= stall_hit ? lo_lim : duty_raw;
          stalled      <= stall_hit;
          sensor_fault <= 1'b0;
        end
        default: begin
          duty         <= lo_lim;
          stalled      <= 1'b0;
          sensor_fault <= 1'b0;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `PPDC_ASSERT_NEXT(a_primed_sticky, primed, primed, "primed flag dropped without reset")
  `PPDC_ASSERT_IMPLY(a_stall_at_floor, out_valid && stalled,
                     (duty == lo_lim) && !sensor_fault, "stall cut-off not at floor duty")
  `PPDC_ASSERT_IMPLY(a_fault_at_floor, out_valid && sensor_fault,
                     (duty == lo_lim) && !stalled, "sensor fault not at floor duty")
  `PPDC_ASSERT_IMPLY(a_duty_in_limits, out_valid && !stalled && !sensor_fault,
                     (duty <= hi_lim) || (duty <= lo_lim), "duty above both limits")

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: pid pwm duty controller testbench
// drives sensor sample requests through the duty controller, predicts each
// duty result in a local fixed point model of the control law and checks
// the results in order while both handshake sides idle at random
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAC = ppdc_pkg::FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 4000;

  // one duty result as the block presents it
  typedef struct packed {
    logic [ppdc_pkg::DUTY_REG_W-1:0] duty;
    logic                            stalled;
    logic                            sensor_fault;
  } duty_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // configuration port
  logic                            cfg_write = 1'b0;
  logic [ppdc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ppdc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // sample channel
  logic                                 in_valid     = 1'b0;
  logic                                 in_stall;
  logic signed [ppdc_pkg::SAMPLE_W-1:0] sample       = '0;
  logic                                 sample_valid = 1'b0;

  // duty channel
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [ppdc_pkg::DUTY_REG_W-1:0] duty;
  logic                            stalled;
  logic                            sensor_fault;

  // idle rates in percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int error_count = 0;
  int quiet_cycles = 0;

  // duty results predicted for accepted requests, oldest first
  duty_result_t pending_duties[$];
  duty_result_t oldest_duty;

  // register copies kept in step with every write
  logic signed [31:0]               target      = '0;
  logic [31:0]                      gain_p      = '0;
  logic [31:0]                      gain_i      = '0;
  logic [31:0]                      gain_d      = '0;
  logic [ppdc_pkg::DUTY_REG_W-1:0]  duty_lo     = '0;
  logic [ppdc_pkg::DUTY_REG_W-1:0]  duty_hi     = ppdc_pkg::DUTY_CEILING_RST;
  logic [ppdc_pkg::STALL_CNT_W-1:0] stall_limit = ppdc_pkg::STALL_SAMPLES_RST;
  logic [ppdc_pkg::DUTY_REG_W-1:0]  stall_floor = ppdc_pkg::STALL_DUTY_MIN_RST;

  // controller state as the block should hold it
  logic signed [31:0]               last_meas   = '0;
  logic signed [79:0]               integ_q     = '0;
  logic [ppdc_pkg::STALL_CNT_W-1:0] same_count  = '0;
  logic                             meas_primed = 1'b0;

  pid_pwm_duty_controller i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .sample_valid (sample_valid),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty         (duty),
    .stalled      (stalled),
    .sensor_fault (sensor_fault)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exact gain times difference, rounded toward minus infinity to q16.16
  function automatic logic signed [79:0] scale_by_gain(logic [31:0] gain,
                                                       logic signed [79:0] v);
    logic signed [79:0] g;
    g = {48'd0, gain};
    return (g * v) >>> FRAC;
  endfunction

  // upper limit is tested first, so with floor above ceiling the value
  // lands on the floor unless it is above the ceiling
  function automatic logic signed [79:0] clamp_q(logic signed [79:0] v,
                                                 logic signed [79:0] lo,
                                                 logic signed [79:0] hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one control period: advances the local controller state and returns
  // the duty result the block has to give for this sample
  function automatic duty_result_t next_duty(logic signed [31:0] meas,
                                             logic meas_ok);
    duty_result_t       r;
    logic signed [79:0] delta;
    logic signed [79:0] err;
    logic signed [79:0] lo_q;
    logic signed [79:0] hi_q;
    logic signed [79:0] duty_q;
    r = '0;
    lo_q = {52'd0, duty_lo, 16'd0};
    hi_q = {52'd0, duty_hi, 16'd0};
    // invalid measurement: floor duty, state untouched
    if (!meas_ok) begin
      r.duty = duty_lo;
      r.sensor_fault = 1'b1;
      return r;
    end
    // first valid measurement only primes the previous value
    if (!meas_primed) begin
      last_meas = meas;
      meas_primed = 1'b1;
      same_count = '0;
      return r;
    end
    delta = meas - last_meas;
    err = target - meas;
    last_meas = meas;
    integ_q = clamp_q(integ_q + scale_by_gain(gain_i, err) - scale_by_gain(gain_p, delta),
                      lo_q, hi_q);
    duty_q = clamp_q(integ_q - scale_by_gain(gain_d, delta), lo_q, hi_q);
    r.duty = duty_q[FRAC+ppdc_pkg::DUTY_REG_W-1:FRAC];
    if (delta != 0) begin
      same_count = '0;
    end else if (same_count != '1) begin
      same_count = same_count + 1'b1;
    end
    // stall cut-off keeps the integrator, only the output drops
    if (r.duty > stall_floor && same_count > stall_limit) begin
      r.duty = duty_lo;
      r.stalled = 1'b1;
    end
    return r;
  endfunction

  // mostly a typical value, sometimes an extreme or a random word under the top mask
  function automatic logic [31:0] pick_value(logic [31:0] top, logic [31:0] typ_max);
    case ($urandom_range(7))
      0: return '0;
      1: return top;
      2: return $urandom & top;
      default: return $urandom_range(typ_max, 0);
    endcase
  endfunction

  // sends one sample request, with a random idle gap in front of it
  task automatic send_sample(logic signed [31:0] meas, logic meas_ok);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      sample <= $urandom;
      sample_valid <= 1'($urandom_range(1));
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    sample <= meas;
    sample_valid <= meas_ok;
    do @(posedge clk); while (in_stall);
    pending_duties.push_back(next_duty(meas, meas_ok));
  endtask

  // stops sending and waits until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [ppdc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      ppdc_pkg::REG_SETPOINT:       target = data;
      ppdc_pkg::REG_GAIN_PROP:      gain_p = data;
      ppdc_pkg::REG_GAIN_INTEG:     gain_i = data;
      ppdc_pkg::REG_GAIN_DERIV:     gain_d = data;
      ppdc_pkg::REG_DUTY_FLOOR:     duty_lo = data[ppdc_pkg::DUTY_REG_W-1:0];
      ppdc_pkg::REG_DUTY_CEILING:   duty_hi = data[ppdc_pkg::DUTY_REG_W-1:0];
      ppdc_pkg::REG_STALL_SAMPLES:  stall_limit = data[ppdc_pkg::STALL_CNT_W-1:0];
      ppdc_pkg::REG_STALL_DUTY_MIN: stall_floor = data[ppdc_pkg::DUTY_REG_W-1:0];
      default: ;
    endcase
  endtask

  // rewrites all registers once the block has gone idle; narrow registers
  // get random junk above their width, which the block must drop
  task automatic apply_config(logic [31:0] sp, logic [31:0] kp, logic [31:0] ki,
                              logic [31:0] kd, logic [11:0] lo, logic [11:0] hi,
                              logic [15:0] lim, logic [11:0] dmin);
    wait_idle();
    write_reg(ppdc_pkg::REG_SETPOINT, sp);
    write_reg(ppdc_pkg::REG_GAIN_PROP, kp);
    write_reg(ppdc_pkg::REG_GAIN_INTEG, ki);
    write_reg(ppdc_pkg::REG_GAIN_DERIV, kd);
    write_reg(ppdc_pkg::REG_DUTY_FLOOR, ($urandom & 32'hFFFF_F000) | lo);
    write_reg(ppdc_pkg::REG_DUTY_CEILING, ($urandom & 32'hFFFF_F000) | hi);
    write_reg(ppdc_pkg::REG_STALL_SAMPLES, ($urandom & 32'hFFFF_0000) | lim);
    write_reg(ppdc_pkg::REG_STALL_DUTY_MIN, ($urandom & 32'hFFFF_F000) | dmin);
    cfg_write <= 1'b0;
  endtask

  // reset defaults: invalid before priming, the priming sample, then a
  // repeated sample with zero gains
  task automatic test_priming();
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh0001_0000, 1'b1);
    send_sample(32'sh0001_0000, 1'b1);
  endtask

  // full scale gains and samples drive both clamps, invalid shows the floor
  task automatic test_gain_extremes();
    apply_config(32'h7FFF_FFFF, '1, '1, '1, 12'd100, 12'd4000, 16'd65535, 12'd4095);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh0000_0000, 1'b1);
  endtask

  // floor above ceiling
  task automatic test_inverted_limits();
    apply_config(32'h0, 32'h0000_8000, 32'h0001_0000, 32'h0002_0000,
                 12'd3000, 12'd1000, 16'd100, 12'd4);
    send_sample(32'sh0000_0000, 1'b1);
    send_sample(32'sh0010_0000, 1'b1);
    send_sample(32'shFFF0_0000, 1'b1);
    send_sample(32'sh0000_0001, 1'b0);
  endtask

  // zero stall limit cuts off on the first repeat, a high duty threshold
  // blocks the cut-off, a lower one lets it through again
  task automatic test_stall_cutoff();
    apply_config(32'h0800_0000, '0, 32'h0001_0000, '0, 12'd0, 12'd4095, 16'd0, 12'd0);
    repeat (5) send_sample(32'sh0000_0000, 1'b1);
    apply_config(32'h0800_0000, '0, 32'h0001_0000, '0, 12'd0, 12'd4095, 16'd3, 12'd4095);
    repeat (3) send_sample(32'sh0000_0000, 1'b1);
    apply_config(32'h0800_0000, '0, 32'h0001_0000, '0, 12'd0, 12'd4095, 16'd3, 12'd5);
    repeat (2) send_sample(32'sh0000_0000, 1'b1);
  endtask

  // random settings, each followed by a random walk around the setpoint
  // with repeats for the stall logic, invalid samples and wild values
  task automatic test_random_traffic(int send_pct, int recv_pct);
    logic signed [31:0] walk;
    logic [31:0]        sp;
    int                 pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (6) begin
      case ($urandom_range(5))
        0: sp = 32'h7FFF_FFFF;
        1: sp = 32'h8000_0000;
        2: sp = $urandom;
        default: sp = int'($urandom_range(1 << 23, 0)) - (1 << 22);
      endcase
      apply_config(sp, pick_value('1, 1 << 18), pick_value('1, 1 << 18),
                   pick_value('1, 1 << 18), 12'(pick_value(4095, 1200)),
                   12'd4095 - 12'(pick_value(4095, 1200)),
                   16'(pick_value(65535, 6)), 12'(pick_value(4095, 300)));
      walk = target + int'($urandom_range(1 << 20, 0)) - (1 << 19);
      repeat (95) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          send_sample($urandom, 1'b0);
        end else if (pick < 11) begin
          send_sample($urandom, 1'b1);
        end else if (pick < 45) begin
          send_sample(walk, 1'b1);
        end else begin
          walk = walk + int'($urandom_range(1 << 18, 0)) - (1 << 17);
          send_sample(walk, 1'b1);
        end
      end
    end
  endtask

  // result checker and receiver stall generator
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_duties.size() == 0) begin
        $display("%0t: unexpected duty result, duty %0d stalled %0b sensor_fault %0b",
                 $time, duty, stalled, sensor_fault);
        error_count++;
      end else begin
        oldest_duty = pending_duties.pop_front();
        if (duty !== oldest_duty.duty) begin
          $display("%0t: duty mismatch, expected %0d, actual %0d",
                   $time, oldest_duty.duty, duty);
          error_count++;
        end
        if (stalled !== oldest_duty.stalled) begin
          $display("%0t: stalled mismatch, expected %0b, actual %0b",
                   $time, oldest_duty.stalled, stalled);
          error_count++;
        end
        if (sensor_fault !== oldest_duty.sensor_fault) begin
          $display("%0t: sensor_fault mismatch, expected %0b, actual %0b",
                   $time, oldest_duty.sensor_fault, sensor_fault);
          error_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog: ends the run when no request moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 64;
    test_priming();
    test_gain_extremes();
    test_inverted_limits();
    test_stall_cutoff();
    test_random_traffic(21, 64);
    test_random_traffic(64, 21);
    test_random_traffic(0, 0);
    wait_idle();
    // room for any stray result past the pipeline depth
    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/ppdc_pkg.sv
sv/pid_pwm_duty_controller.sv
test/tb_top.sv
